/* rtl/core/motion_window_force_accumulator_core_macros.svh */
// Assertion helpers for the motion window force accumulator core.
`ifndef MOTION_WINDOW_FORCE_ACCUMULATOR_CORE_MACROS_SVH
`define MOTION_WINDOW_FORCE_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication
`define MWFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MWFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mwfa_pkg.sv */
`timescale 1ns / 1ps

package mwfa_pkg;

    localparam int LUMA_W     = 8;
    localparam int COORD_W    = 12;
    localparam int FW_W       = 13;
    localparam int NF_W       = 8;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 28;
    localparam int OUT_W      = 32;
    localparam int PROD_W     = SUM_W + GAIN_W;
    localparam int Q_W        = PROD_W - 8;
    localparam int REM_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;

    localparam logic [COORD_W-1:0] LEFT_RST  = 12'd0;
    localparam logic [COORD_W-1:0] TOP_RST   = 12'd0;
    localparam logic [FW_W-1:0]    FW_RST    = 13'd640;
    localparam logic [NF_W-1:0]    NF_RST    = 8'd5;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd2560;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEFT,
        CFG_WINDOW_TOP,
        CFG_FRAME_WIDTH,
        CFG_NOISE_FLOOR,
        CFG_FORCE_GAIN
    } t_cfg_idx;

endpackage

/* rtl/core/motion_window_force_accumulator_core.sv */
// Each sum update is a single saturating add per cycle; frame-end sums enter the scaling pipe.
// Throughput: one pixel word per cycle while no frame-end word waits on a full scaling pipe.
// Non-frame-end words leave at the accumulator and never wait on the result side.
// The five-stage scaling pipe (gain multiply, reciprocal of 255, correction) can hold results.
// Reset (synchronous, active low) clears valids and sums and loads register defaults.
`timescale 1ns / 1ps
`include "motion_window_force_accumulator_core_macros.svh"

module motion_window_force_accumulator_core
    import mwfa_pkg::*;
#(
    parameter int WINDOW_SIZE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // prev_luma[7:0], cur_luma[15:8], column[27:16], row[39:28]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // frame_end
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // force_x[31:0], force_y[63:32]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int DW = $clog2(WINDOW_SIZE / 2 + 1) + 1;
    localparam int PW = LUMA_W + 1 + DW;
    localparam int CW = COORD_W + 3;
    localparam logic signed [CW-1:0] WIN_S  = CW'(WINDOW_SIZE);
    localparam logic signed [CW-1:0] HALF_S = CW'(WINDOW_SIZE / 2);
    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((64'sd1 <<< (SUM_W - 1)) - 1);
    localparam logic signed [SUM_W:0] SUM_MIN = (SUM_W+1)'(-(64'sd1 <<< (SUM_W - 1)));
    localparam logic [Q_W-1:0] Q_POS_MAX = Q_W'((64'd1 << (OUT_W - 1)) - 1);
    localparam logic [Q_W-1:0] Q_NEG_MAX = Q_W'(64'd1 << (OUT_W - 1));

    function automatic logic signed [SUM_W-1:0] f_sat_sum(input logic signed [SUM_W:0] v);
        if (v > SUM_MAX) begin
            f_sat_sum = SUM_MAX[SUM_W-1:0];
        end else if (v < SUM_MIN) begin
            f_sat_sum = SUM_MIN[SUM_W-1:0];
        end else begin
            f_sat_sum = v[SUM_W-1:0];
        end
    endfunction

    function automatic logic [PROD_W-1:0] f_mag_gain(input logic signed [SUM_W-1:0] s,
                                                     input logic [GAIN_W-1:0] g);
        logic [SUM_W-1:0] mag;
        mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        f_mag_gain = PROD_W'(mag) * PROD_W'(g);
    endfunction

    // floor(a/255) from below: sum of a >> 8k, short by less than six
    function automatic logic [Q_W-1:0] f_q0(input logic [PROD_W-1:0] a);
        logic [Q_W-1:0] acc;
        acc = '0;
        for (int k = 1; k <= (PROD_W - 1) / 8; k++) begin
            acc = acc + Q_W'(a >> (8 * k));
        end
        f_q0 = acc;
    endfunction

    function automatic logic [REM_W-1:0] f_rem(input logic [PROD_W-1:0] a,
                                               input logic [Q_W-1:0] q0);
        logic [PROD_W-1:0] r;
        r = a - {q0, 8'b0} + PROD_W'(q0);
        f_rem = r[REM_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] f_final(input logic [Q_W-1:0] q0,
                                                 input logic [REM_W-1:0] rem,
                                                 input logic neg);
        logic [REM_W-1:0] t;
        logic [Q_W-1:0]   q;
        t = rem + (rem >> 8) + REM_W'(1);
        q = q0 + Q_W'(t[REM_W-1:8]);
        if (neg) begin
            f_final = (q > Q_NEG_MAX) ? Q_NEG_MAX[OUT_W-1:0] : (~q[OUT_W-1:0] + OUT_W'(1));
        end else begin
            f_final = (q > Q_POS_MAX) ? Q_POS_MAX[OUT_W-1:0] : q[OUT_W-1:0];
        end
    endfunction

    logic [COORD_W-1:0] r_left;
    logic [COORD_W-1:0] r_top;
    logic [FW_W-1:0]    r_fw;
    logic [NF_W-1:0]    r_nf;
    logic [GAIN_W-1:0]  r_gain;

    logic               r_in_v;
    logic [LUMA_W-1:0]  r_in_prev;
    logic [LUMA_W-1:0]  r_in_cur;
    logic [COORD_W-1:0] r_in_col;
    logic [COORD_W-1:0] r_in_row;
    logic               r_in_last;

    logic                 r_pr_v;
    logic signed [PW-1:0] r_pr_x;
    logic signed [PW-1:0] r_pr_y;
    logic                 r_pr_last;

    logic signed [SUM_W-1:0] r_sum_x;
    logic signed [SUM_W-1:0] r_sum_y;
    logic signed [SUM_W-1:0] n_sum_x;
    logic signed [SUM_W-1:0] n_sum_y;

    logic                    r_r1_v;
    logic signed [SUM_W-1:0] r_r1_x;
    logic signed [SUM_W-1:0] r_r1_y;
    logic                    r_r2_v;
    logic [PROD_W-1:0]       r_r2_ax;
    logic [PROD_W-1:0]       r_r2_ay;
    logic                    r_r2_nx;
    logic                    r_r2_ny;
    logic                    r_r3_v;
    logic [PROD_W-1:0]       r_r3_ax;
    logic [PROD_W-1:0]       r_r3_ay;
    logic [Q_W-1:0]          r_r3_qx;
    logic [Q_W-1:0]          r_r3_qy;
    logic                    r_r3_nx;
    logic                    r_r3_ny;
    logic                    r_r4_v;
    logic [Q_W-1:0]          r_r4_qx;
    logic [Q_W-1:0]          r_r4_qy;
    logic [REM_W-1:0]        r_r4_rx;
    logic [REM_W-1:0]        r_r4_ry;
    logic                    r_r4_nx;
    logic                    r_r4_ny;
    logic                    r_out_v;
    logic [OUT_W-1:0]        r_out_x;
    logic [OUT_W-1:0]        r_out_y;

    logic out_rdy, r4_rdy, r3_rdy, r2_rdy, r1_rdy, pr_adv, pr_rdy, in_rdy;

    assign out_rdy = !r_out_v || m_axis_tready;
    assign r4_rdy  = !r_r4_v || out_rdy;
    assign r3_rdy  = !r_r3_v || r4_rdy;
    assign r2_rdy  = !r_r3_v || r3_rdy ? (!r_r2_v || r3_rdy) : !r_r2_v;
    assign r1_rdy  = !r_r1_v || r2_rdy;
    assign pr_adv  = r_pr_v && (!r_pr_last || r1_rdy);
    assign pr_rdy  = !r_pr_v || pr_adv;
    assign in_rdy  = !r_in_v || pr_rdy;

    assign s_axis_tready = in_rdy;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_y, r_out_x};

    logic [LUMA_W-1:0]       w_abs;
    logic [LUMA_W-1:0]       w_d;
    logic signed [CW-1:0]    w_m;
    logic signed [CW-1:0]    w_left;
    logic signed [CW-1:0]    w_top;
    logic signed [CW-1:0]    w_row;
    logic                    w_in_win;
    logic signed [CW-1:0]    w_dx_w;
    logic signed [CW-1:0]    w_dy_w;
    logic signed [DW-1:0]    w_dx;
    logic signed [DW-1:0]    w_dy;
    logic signed [LUMA_W:0]  w_ds;
    logic signed [PW-1:0]    w_mx;
    logic signed [PW-1:0]    w_my;
    logic signed [SUM_W:0]   w_ax;
    logic signed [SUM_W:0]   w_ay;

    always_comb begin
        w_abs    = (r_in_cur >= r_in_prev) ? (r_in_cur - r_in_prev) : (r_in_prev - r_in_cur);
        w_d      = (w_abs > r_nf) ? (w_abs - r_nf) : '0;
        w_left   = $signed({3'b0, r_left});
        w_top    = $signed({3'b0, r_top});
        w_row    = $signed({3'b0, r_in_row});
        w_m      = $signed({2'b0, r_fw}) - CW'(1) - $signed({3'b0, r_in_col});
        w_in_win = (w_m >= w_left) && (w_m < w_left + WIN_S) &&
                   (w_row >= w_top) && (w_row < w_top + WIN_S);
        w_dx_w   = w_left + HALF_S - w_m;
        w_dy_w   = w_top + HALF_S - w_row;
        w_dx     = DW'(w_dx_w);
        w_dy     = DW'(w_dy_w);
        w_ds     = $signed({1'b0, w_d});
        w_mx     = w_ds * w_dx;
        w_my     = w_ds * w_dy;
        w_ax     = (SUM_W+1)'(r_sum_x) + (SUM_W+1)'(r_pr_x);
        w_ay     = (SUM_W+1)'(r_sum_y) + (SUM_W+1)'(r_pr_y);
        n_sum_x  = f_sat_sum(w_ax);
        n_sum_y  = f_sat_sum(w_ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= LEFT_RST;
            r_top   <= TOP_RST;
            r_fw    <= FW_RST;
            r_nf    <= NF_RST;
            r_gain  <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW_LEFT: r_left <= i_cfg_data[COORD_W-1:0];
                CFG_WINDOW_TOP:  r_top  <= i_cfg_data[COORD_W-1:0];
                CFG_FRAME_WIDTH: r_fw   <= i_cfg_data[FW_W-1:0];
                CFG_NOISE_FLOOR: r_nf   <= i_cfg_data[NF_W-1:0];
                CFG_FORCE_GAIN:  r_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_pr_v  <= 1'b0;
            r_r1_v  <= 1'b0;
            r_r2_v  <= 1'b0;
            r_r3_v  <= 1'b0;
            r_r4_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else begin
            if (in_rdy) begin
                r_in_v <= s_axis_tvalid;
            end
            if (pr_rdy) begin
                r_pr_v <= r_in_v;
            end
            if (pr_adv) begin
                r_sum_x <= r_pr_last ? '0 : n_sum_x;
                r_sum_y <= r_pr_last ? '0 : n_sum_y;
            end
            if (r1_rdy) begin
                r_r1_v <= pr_adv && r_pr_last;
            end
            if (r2_rdy) begin
                r_r2_v <= r_r1_v;
            end
            if (r3_rdy) begin
                r_r3_v <= r_r2_v;
            end
            if (r4_rdy) begin
                r_r4_v <= r_r3_v;
            end
            if (out_rdy) begin
                r_out_v <= r_r4_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy) begin
            r_in_prev <= s_axis_tdata[7:0];
            r_in_cur  <= s_axis_tdata[15:8];
            r_in_col  <= s_axis_tdata[27:16];
            r_in_row  <= s_axis_tdata[39:28];
            r_in_last <= s_axis_tlast;
        end
        if (pr_rdy) begin
            r_pr_x    <= w_in_win ? w_mx : '0;
            r_pr_y    <= w_in_win ? w_my : '0;
            r_pr_last <= r_in_last;
        end
        if (r1_rdy) begin
            r_r1_x <= n_sum_x;
            r_r1_y <= n_sum_y;
        end
        if (r2_rdy) begin
            r_r2_ax <= f_mag_gain(r_r1_x, r_gain);
            r_r2_ay <= f_mag_gain(r_r1_y, r_gain);
            r_r2_nx <= r_r1_x[SUM_W-1];
            r_r2_ny <= r_r1_y[SUM_W-1];
        end
        if (r3_rdy) begin
            r_r3_ax <= r_r2_ax;
            r_r3_ay <= r_r2_ay;
            r_r3_qx <= f_q0(r_r2_ax);
            r_r3_qy <= f_q0(r_r2_ay);
            r_r3_nx <= r_r2_nx;
            r_r3_ny <= r_r2_ny;
        end
        if (r4_rdy) begin
            r_r4_qx <= r_r3_qx;
            r_r4_qy <= r_r3_qy;
            r_r4_rx <= f_rem(r_r3_ax, r_r3_qx);
            r_r4_ry <= f_rem(r_r3_ay, r_r3_qy);
            r_r4_nx <= r_r3_nx;
            r_r4_ny <= r_r3_ny;
        end
        if (out_rdy) begin
            r_out_x <= f_final(r_r4_qx, r_r4_rx, r_r4_nx);
            r_out_y <= f_final(r_r4_qy, r_r4_ry, r_r4_ny);
        end
    end

    `MWFA_ASSERT_IMP(a_stall_needs_word, i_clk, i_rst_n, !s_axis_tready, r_in_v, "input stalled while input stage empty")
    `MWFA_ASSERT_NXT(a_sum_cleared, i_clk, i_rst_n, pr_adv && r_pr_last, (r_sum_x == '0) && (r_sum_y == '0), "sums not cleared after frame end")
    `MWFA_ASSERT_IMP(a_out_from_pipe, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(r_r4_v), "result word without scaling stage word")

endmodule

/* tb/tb_motion_window_force_accumulator_core.sv */
`timescale 1ns / 1ps

module tb_motion_window_force_accumulator_core;
    import mwfa_pkg::*;

    localparam int     CLK_PERIOD    = 12;
    localparam int     WIN           = 64;
    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam int     DRAIN_CYCLES  = 16;
    localparam int     ITEM_TARGET   = 1550;
    localparam int     SAT_FRAME_LEN = 1100;
    localparam int     HOLD_CYCLES   = 150;
    localparam int     COORD_SPAN    = 1 << COORD_W;
    localparam longint SUM_HI        = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO        = -(longint'(1) <<< (SUM_W - 1));
    localparam longint OUT_HI        = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint OUT_LO        = -(longint'(1) <<< (OUT_W - 1));
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_FORCE_GAIN + 1);

    typedef struct {
        logic [LUMA_W-1:0]  prev_luma;
        logic [LUMA_W-1:0]  cur_luma;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               frame_end;
    } t_pixel;

    typedef struct {
        logic signed [OUT_W-1:0] force_x;
        logic signed [OUT_W-1:0] force_y;
    } t_force;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // prev_luma[7:0], cur_luma[15:8], column[27:16], row[39:28]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // frame_end
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // force_x[31:0], force_y[63:32]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // pixel words waiting to be sent and force words still owed by the block
    t_pixel pixel_q[$];
    t_force force_q[$];

    // predictor copy of the registers and the sums
    logic [COORD_W-1:0]      win_left;
    logic [COORD_W-1:0]      win_top;
    logic [FW_W-1:0]         frame_w;
    logic [NF_W-1:0]         floor_nf;
    logic [GAIN_W-1:0]       gain_q8;
    logic signed [SUM_W-1:0] acc_x;
    logic signed [SUM_W-1:0] acc_y;

    // register values the stimulus aims its pixels at
    int gen_left = LEFT_RST;
    int gen_top  = TOP_RST;
    int gen_fw   = FW_RST;
    int gen_nf   = NF_RST;

    int     cycle_count    = 0;
    int     errors         = 0;
    int     pixels_taken   = 0;
    int     frames_checked = 0;
    int     settings_used  = 1;
    int     stall_pct      = 0;
    bit     tx_gaps        = 1'b0;
    int     burst_left     = 0;
    int     gap_left       = 0;
    int     hold_request   = 0;
    int     hold_left      = 0;
    logic   pixel_taken    = 1'b0;
    t_pixel drv_px;
    t_pixel seen_px;
    t_force owed;

    motion_window_force_accumulator_core #(
        .WINDOW_SIZE(WIN)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic longint saturate(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] scale_force(input logic signed [SUM_W-1:0] s);
        longint v;
        longint g;
        v = s;
        g = gain_q8;
        v = saturate(v * g / 255, OUT_LO, OUT_HI);
        return v[OUT_W-1:0];
    endfunction

    function automatic void accumulate_pixel(input t_pixel px);
        longint p, c, d, col, row, m, lft, tp, fw, nf, nx, ny;
        t_force f;
        p   = px.prev_luma;
        c   = px.cur_luma;
        col = px.column;
        row = px.row;
        fw  = frame_w;
        nf  = floor_nf;
        lft = win_left;
        tp  = win_top;
        d = (c > p) ? c - p : p - c;
        d = d - nf;
        if (d < 0) d = 0;
        m = fw - 1 - col;
        if (m >= lft && m < lft + WIN && row >= tp && row < tp + WIN) begin
            nx = saturate(acc_x + d * (lft + WIN / 2 - m), SUM_LO, SUM_HI);
            ny = saturate(acc_y + d * (tp + WIN / 2 - row), SUM_LO, SUM_HI);
            acc_x = nx[SUM_W-1:0];
            acc_y = ny[SUM_W-1:0];
        end
        if (px.frame_end) begin
            f.force_x = scale_force(acc_x);
            f.force_y = scale_force(acc_y);
            force_q.push_back(f);
            acc_x = '0;
            acc_y = '0;
        end
    endfunction

    // predictor and checker
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t run stopped after %0d cycles, %0d force words still owed",
                     $time, CYCLE_LIMIT, force_q.size());
            $display("CHECKS FAILED");
            $finish;
        end else if (!i_rst_n) begin
            win_left    = LEFT_RST;
            win_top     = TOP_RST;
            frame_w     = FW_RST;
            floor_nf    = NF_RST;
            gain_q8     = GAIN_RST;
            acc_x       = '0;
            acc_y       = '0;
            pixel_taken <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (force_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected force word: expected none, got %h",
                             $time, m_axis_tdata);
                end else begin
                    owed = force_q.pop_front();
                    frames_checked++;
                    if (m_axis_tdata[OUT_W-1:0] !== owed.force_x) begin
                        errors++;
                        $display("%0t force_x mismatch: expected %0d, got %0d", $time,
                                 owed.force_x, $signed(m_axis_tdata[OUT_W-1:0]));
                    end
                    if (m_axis_tdata[2*OUT_W-1:OUT_W] !== owed.force_y) begin
                        errors++;
                        $display("%0t force_y mismatch: expected %0d, got %0d", $time,
                                 owed.force_y, $signed(m_axis_tdata[2*OUT_W-1:OUT_W]));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_LEFT: win_left = i_cfg_data[COORD_W-1:0];
                    CFG_WINDOW_TOP:  win_top  = i_cfg_data[COORD_W-1:0];
                    CFG_FRAME_WIDTH: frame_w  = i_cfg_data[FW_W-1:0];
                    CFG_NOISE_FLOOR: floor_nf = i_cfg_data[NF_W-1:0];
                    CFG_FORCE_GAIN:  gain_q8  = i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                {seen_px.row, seen_px.column, seen_px.cur_luma, seen_px.prev_luma} = s_axis_tdata;
                seen_px.frame_end = s_axis_tlast;
                pixels_taken++;
                accumulate_pixel(seen_px);
            end
            pixel_taken <= s_axis_tvalid && s_axis_tready;
        end
    end

    // pixel driver: bursts, with gaps when enabled, hold the word until taken
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || pixel_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                drv_px = pixel_q.pop_front();
                s_axis_tdata  <= {drv_px.row, drv_px.column, drv_px.cur_luma, drv_px.prev_luma};
                s_axis_tlast  <= drv_px.frame_end;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    if (tx_gaps) gap_left = $urandom_range(1, 8);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // force receiver: random stalls, plus a long hold when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left = hold_request - 1;
            hold_request = 0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_window(input int left, input int top, input int fw, input int nf,
                              input int gain);
        write_reg(CFG_WINDOW_LEFT, CFG_DATA_W'(left));
        write_reg(CFG_WINDOW_TOP, CFG_DATA_W'(top));
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(fw));
        write_reg(CFG_NOISE_FLOOR, CFG_DATA_W'(nf));
        write_reg(CFG_FORCE_GAIN, CFG_DATA_W'(gain));
        gen_left = left;
        gen_top  = top;
        gen_fw   = fw;
        gen_nf   = nf;
        settings_used++;
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_axis_tvalid || force_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_pixel(input int prev, input int cur, input int col, input int row,
                               input bit last);
        t_pixel px;
        px.prev_luma = prev[LUMA_W-1:0];
        px.cur_luma  = cur[LUMA_W-1:0];
        px.column    = col[COORD_W-1:0];
        px.row       = row[COORD_W-1:0];
        px.frame_end = last;
        pixel_q.push_back(px);
    endtask

    function automatic t_pixel random_pixel(input bit in_window);
        t_pixel px;
        int lp, dl, cl, m, col, r;
        px.prev_luma = LUMA_W'($urandom);
        px.cur_luma  = LUMA_W'($urandom);
        px.column    = COORD_W'($urandom);
        px.row       = COORD_W'($urandom);
        px.frame_end = 1'b0;
        case ($urandom_range(3))
            0: ;
            1: begin
                px.prev_luma = $urandom_range(1) ? 8'hFF : 8'h00;
                px.cur_luma  = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            2: begin
                lp = px.prev_luma;
                dl = gen_nf + int'($urandom_range(4)) - 2;
                cl = $urandom_range(1) ? lp + dl : lp - dl;
                if (cl < 0) cl = 0;
                if (cl > 255) cl = 255;
                px.cur_luma = cl[LUMA_W-1:0];
            end
            default: px.cur_luma = px.prev_luma;
        endcase
        if (in_window) begin
            m   = gen_left + int'($urandom_range(WIN - 1));
            col = gen_fw - 1 - m;
            r   = gen_top + int'($urandom_range(WIN - 1));
            if (col >= 0 && col < COORD_SPAN) px.column = col[COORD_W-1:0];
            if (r < COORD_SPAN) px.row = r[COORD_W-1:0];
        end
        return px;
    endfunction

    task automatic queue_random_frames(input int n_items);
        int items_left, len;
        t_pixel px;
        items_left = n_items;
        while (items_left > 0) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(200, 1200) : $urandom_range(1, 30);
            if (len > items_left) len = items_left;
            for (int i = 0; i < len; i++) begin
                px = random_pixel($urandom_range(99) < 80);
                px.frame_end = (i == len - 1);
                pixel_q.push_back(px);
            end
            items_left -= len;
        end
    endtask

    initial begin
        int fw, n;
        t_pixel px;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: window corners, dead pixels, columns past the frame edge
        queue_pixel(0, 255, 639, 0, 0);
        queue_pixel(255, 0, 576, 63, 0);
        queue_pixel(128, 128, 600, 10, 0);
        queue_pixel(10, 13, 610, 20, 0);
        queue_pixel(0, 255, 4095, 5, 0);
        queue_pixel(0, 255, 640, 5, 0);
        queue_pixel(0, 255, 575, 64, 0);
        queue_pixel(200, 50, 620, 30, 1);
        queue_pixel(255, 0, 4095, 4095, 1);
        queue_pixel(0, 0, 0, 0, 1);
        wait_drained();

        // widest frame, full gain: push both forces past the 32-bit range
        set_window(0, 0, 4096, 0, 65535);
        queue_pixel(0, 255, 4095, 0, 0);
        queue_pixel(255, 0, 4032, 63, 1);
        for (int i = 0; i < SAT_FRAME_LEN; i++)
            queue_pixel(0, 255, 4095, 63, i == SAT_FRAME_LEN - 1);
        wait_drained();

        // oversized write data and spare register indexes
        write_reg(CFG_WINDOW_LEFT, 16'hF000);
        write_reg(CFG_WINDOW_TOP, 16'hFFFF);
        write_reg(CFG_FRAME_WIDTH, 16'hE001);
        write_reg(CFG_NOISE_FLOOR, 16'hFF03);
        write_reg(CFG_FORCE_GAIN, 16'h0001);
        for (int k = CFG_SPARE_FIRST; k < (1 << CFG_IDX_W); k++)
            write_reg(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
        gen_left = 0;
        gen_top  = 4095;
        gen_fw   = 1;
        gen_nf   = 3;
        settings_used++;
        queue_pixel(0, 255, 0, 4095, 1);
        queue_pixel(255, 255, 1, 4095, 1);
        stall_pct = 30;
        tx_gaps   = 1'b1;
        queue_random_frames(60);
        wait_drained();

        set_window(4032, 4032, 4096, 255, 0);
        queue_random_frames(100);
        wait_drained();

        // zero frame width: every column lands left of the frame
        set_window($urandom_range(4095), $urandom_range(4095), 0, 7, 40000);
        stall_pct = 60;
        queue_random_frames(80);
        wait_drained();

        // long output stall with single-pixel frames queued up behind it
        set_window(100, 37, 300, 10, 256);
        stall_pct    = 0;
        tx_gaps      = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 80; i++) begin
            px = random_pixel(1'b1);
            px.frame_end = 1'b1;
            pixel_q.push_back(px);
        end
        wait_drained();

        while (pixels_taken < ITEM_TARGET) begin
            fw = $urandom_range(1, 4096);
            set_window(($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(fw - 1),
                       $urandom_range(4095), fw,
                       ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(20),
                       $urandom_range(65535));
            case ($urandom_range(2))
                0: stall_pct = 0;
                1: stall_pct = 25;
                default: stall_pct = 70;
            endcase
            tx_gaps = $urandom_range(1);
            n = $urandom_range(40, 120);
            queue_random_frames(n);
            wait_drained();
        end

        $display("Ran %0d pixel words and checked %0d frame forces over %0d register settings,",
                 pixels_taken, frames_checked, settings_used);
        $display("with clamped forces, off-frame columns, spare writes and a stalled output.");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
